>>> design/nearest_palette_color_search_macros.svh
// assertion macros for the nearest palette color search checker
// expects clk_i and rst_ni (active low) in the scope of each use
`ifndef NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define NPCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("npcs check failed");

// consequent must hold in the cycle after the antecedent
`define NPCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("npcs check failed");

`endif

>>> design/npcs_pkg.sv
// shared types and constants for the nearest palette color search
// no dependencies
package npcs_pkg;

  // palette geometry
  localparam int unsigned PALETTE_DEPTH = 64;
  localparam int unsigned ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int unsigned CNT_LIM_W     = $clog2(PALETTE_DEPTH + 1);

  // fixed field widths
  localparam int unsigned COLOR_W  = 12;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned DIST_W   = 15;

  // channel weights
  localparam logic [6:0] W_RED   = 7'd30;
  localparam logic [6:0] W_GREEN = 7'd59;
  localparam logic [6:0] W_BLUE  = 7'd11;

  // item function codes
  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  // rgb444 color split into nibbles
  typedef struct packed {
    logic [NIB_W-1:0] red;
    logic [NIB_W-1:0] green;
    logic [NIB_W-1:0] blue;
  } color_t;

endpackage

>>> design/npcs_in_if.sv
// input item channel of the nearest palette color search
// depends on npcs_pkg
interface npcs_in_if import npcs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [IDX_W-1:0]    entry_index;
  logic [COLOR_W-1:0]  entry_color;
  logic [CHAN_W-1:0]   query_red;
  logic [CHAN_W-1:0]   query_green;
  logic [CHAN_W-1:0]   query_blue;

  modport source (output valid, func, entry_index, entry_color,
                  query_red, query_green, query_blue, input ready);
  modport sink   (input valid, func, entry_index, entry_color,
                  query_red, query_green, query_blue, output ready);
endinterface

>>> design/npcs_out_if.sv
// result channel of the nearest palette color search
// depends on npcs_pkg
interface npcs_out_if import npcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] best_index;

  modport source (output valid, best_index, input ready);
  modport sink   (input valid, best_index, output ready);
endinterface

>>> design/npcs_cfg_if.sv
// configuration write channel of the nearest palette color search
// depends on npcs_pkg
interface npcs_cfg_if import npcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> design/npcs_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module npcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/npcs_dist.sv
// weighted squared rgb distance between a palette entry and the query
// depends on npcs_pkg
module npcs_dist import npcs_pkg::*; (
  input  color_t              entry_i,
  input  color_t              query_i,
  output logic [DIST_W-1:0]   dist_o
);

  logic [NIB_W-1:0]   dr, dg, db;
  logic [2*NIB_W-1:0] sq_r, sq_g, sq_b;

  // absolute channel differences
  always_comb begin
    dr = (entry_i.red   > query_i.red)   ? entry_i.red   - query_i.red
                                         : query_i.red   - entry_i.red;
    dg = (entry_i.green > query_i.green) ? entry_i.green - query_i.green
                                         : query_i.green - entry_i.green;
    db = (entry_i.blue  > query_i.blue)  ? entry_i.blue  - query_i.blue
                                         : query_i.blue  - entry_i.blue;
  end

  // squares
  assign sq_r = (2*NIB_W)'(dr) * (2*NIB_W)'(dr);
  assign sq_g = (2*NIB_W)'(dg) * (2*NIB_W)'(dg);
  assign sq_b = (2*NIB_W)'(db) * (2*NIB_W)'(db);

  // weighted sum, at most 100 * 225 so it fits the distance width
  assign dist_o = DIST_W'(sq_r) * DIST_W'(W_RED)
                + DIST_W'(sq_g) * DIST_W'(W_GREEN)
                + DIST_W'(sq_b) * DIST_W'(W_BLUE);

endmodule

>>> design/npcs_seq.sv
// search sequencer: walks the palette, tracks the best entry, holds the result
// depends on npcs_pkg; drives the ram read address and consumes npcs_dist
module npcs_seq import npcs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_func_i,
  input  color_t             in_query_i,
  input  logic [CFG_W-1:0]   color_count_i,
  output color_t             query_o,
  output logic [ADDR_W-1:0]  raddr_o,
  input  logic [DIST_W-1:0]  dist_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IDX_W-1:0]   best_index_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_RESULT = 3'b100
  } state_e;

  state_e                state_q, state_d;
  color_t                query_q, query_d;
  logic [CNT_LIM_W-1:0]  limit_q, limit_d;
  logic [CNT_LIM_W-1:0]  issue_q, issue_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0]     rd_idx_q, rd_idx_d;
  logic                  dist_vld_q, dist_vld_d;
  logic [ADDR_W-1:0]     dist_idx_q, dist_idx_d;
  logic [DIST_W-1:0]     dist_q, dist_d;
  logic [ADDR_W-1:0]     best_q, best_d;
  logic [DIST_W-1:0]     best_dist_q, best_dist_d;
  logic                  out_vld_q, out_vld_d;
  logic [IDX_W-1:0]      out_idx_q, out_idx_d;
  logic                  query_xfer;
  logic [CNT_LIM_W-1:0]  limit_new;

  assign in_ready_o = (state_q == ST_IDLE);
  assign query_xfer = in_valid_i && in_ready_o && (in_func_i == FUNC_QUERY);

  // saturate the entry count to the store depth
  assign limit_new = (32'(color_count_i) > PALETTE_DEPTH) ? CNT_LIM_W'(PALETTE_DEPTH)
                                                          : CNT_LIM_W'(color_count_i);

  // sequencer and compare
  always_comb begin
    state_d     = state_q;
    query_d     = query_q;
    limit_d     = limit_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    dist_vld_d  = rd_vld_q;
    dist_idx_d  = rd_idx_q;
    dist_d      = dist_i;
    best_d      = best_q;
    best_dist_d = best_dist_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_idx_d   = out_idx_q;

    case (state_q)
      ST_IDLE: begin
        if (query_xfer) begin
          query_d     = in_query_i;
          limit_d     = limit_new;
          issue_d     = '0;
          best_d      = '0;
          best_dist_d = '1;
          state_d     = (limit_new == '0) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one palette read per cycle
        if (issue_q < limit_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = issue_q[ADDR_W-1:0];
          issue_d  = issue_q + 1'b1;
        end
        // strict less keeps the lowest index on ties
        if (dist_vld_q && (dist_q < best_dist_q)) begin
          best_d      = dist_idx_q;
          best_dist_d = dist_q;
        end
        if ((issue_q == limit_q) && !rd_vld_q && !dist_vld_q) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // load the output register once it is free
        if (!out_vld_q || out_ready_i) begin
          out_vld_d = 1'b1;
          out_idx_d = IDX_W'(best_q);
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_vld_q   <= 1'b0;
      dist_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      issue_q    <= '0;
      limit_q    <= '0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= rd_vld_d;
      dist_vld_q <= dist_vld_d;
      out_vld_q  <= out_vld_d;
      issue_q    <= issue_d;
      limit_q    <= limit_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    query_q     <= query_d;
    rd_idx_q    <= rd_idx_d;
    dist_idx_q  <= dist_idx_d;
    dist_q      <= dist_d;
    best_q      <= best_d;
    best_dist_q <= best_dist_d;
    out_idx_q   <= out_idx_d;
  end

  assign query_o      = query_q;
  assign raddr_o      = issue_q[ADDR_W-1:0];
  assign out_valid_o  = out_vld_q;
  assign best_index_o = out_idx_q;

endmodule

>>> design/nearest_palette_color_search.sv
// A load item writes one palette entry and the block stays ready for the
// next item. A query item scans color_count entries (color_count saturated
// at the store depth) before its result is offered: the single read port of
// the palette ram walks one entry per cycle through a shared distance unit
// and a compare stage, then the pipeline drains and the output register is
// loaded once it is free. With an empty palette the query answers entry 0
// without a scan. The input is not ready while a query is searched; a result
// waiting on the output does not block loads or configuration. No clearing
// pass runs after reset.
// top level; depends on npcs_pkg, the channel interfaces, npcs_ram,
// npcs_dist and npcs_seq
module nearest_palette_color_search import npcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  npcs_cfg_if.sink   cfg_i,
  npcs_in_if.sink    item_i,
  npcs_out_if.source result_o
);

  logic [CFG_W-1:0]   color_count_q;
  logic               load_we;
  logic [COLOR_W-1:0] rdata;
  logic [ADDR_W-1:0]  raddr;
  logic [DIST_W-1:0]  entry_dist;
  color_t             query;
  color_t             in_query;

  // configuration register, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_count_q <= '0;
    end else if (cfg_i.valid) begin
      color_count_q <= cfg_i.data;
    end
  end

  // palette write on a load transfer inside the store
  assign load_we = item_i.valid && item_i.ready && (item_i.func == FUNC_LOAD)
                   && (32'(item_i.entry_index) < PALETTE_DEPTH);

  npcs_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (ADDR_W'(item_i.entry_index)),
    .wdata_i (item_i.entry_color),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  npcs_dist u_dist (
    .entry_i (color_t'(rdata)),
    .query_i (query),
    .dist_o  (entry_dist)
  );

  // keep only the top nibble of each query channel
  assign in_query = '{red:   item_i.query_red[CHAN_W-1 -: NIB_W],
                      green: item_i.query_green[CHAN_W-1 -: NIB_W],
                      blue:  item_i.query_blue[CHAN_W-1 -: NIB_W]};

  npcs_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (item_i.valid),
    .in_ready_o    (item_i.ready),
    .in_func_i     (item_i.func),
    .in_query_i    (in_query),
    .color_count_i (color_count_q),
    .query_o       (query),
    .raddr_o       (raddr),
    .dist_i        (entry_dist),
    .out_valid_o   (result_o.valid),
    .out_ready_i   (result_o.ready),
    .best_index_o  (result_o.best_index)
  );

endmodule

>>> design/npcs_checker.sv
// port-level checks for the nearest palette color search, bound to the top
// depends on npcs_pkg and nearest_palette_color_search_macros.svh
`include "nearest_palette_color_search_macros.svh"

module npcs_checker import npcs_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_ready_i,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             in_func_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [IDX_W-1:0] best_index_i
);

  // configuration is always taken
  `NPCS_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready_i)

  // a load leaves the input ready
  `NPCS_ASSERT_NEXT(a_load_keeps_ready,
    in_valid_i && in_ready_i && (in_func_i == FUNC_LOAD), in_ready_i)

  // a query holds off the input while it searches
  `NPCS_ASSERT_NEXT(a_query_busy,
    in_valid_i && in_ready_i && (in_func_i == FUNC_QUERY), !in_ready_i)

  // a stalled result stays offered and unchanged
  `NPCS_ASSERT_NEXT(a_result_held, out_valid_i && !out_ready_i,
    out_valid_i && $stable(best_index_i))

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_ready_i  (cfg_i.ready),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .in_func_i    (item_i.func),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .best_index_i (result_o.best_index)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for nearest_palette_color_search: palette loads, nearest
// color queries and color count writes under random item and result flow control
// depends on npcs_pkg, the npcs cfg, input and result interfaces and the block itself
module tb_top;
  import npcs_pkg::*;

  localparam int unsigned HALF_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned NUM_PHASES      = 10;
  localparam int unsigned ITEMS_PER_PHASE = 188;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned TAIL_CYCLES     = 80;
  localparam int unsigned HOLD_CYCLES     = 500;
  localparam int unsigned STALL_LIMIT     = 5000;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned NUM_ROWS        = 18;
  localparam int unsigned RANDOM_PHASE    = 7;
  localparam int unsigned PRESSURE_PHASE  = NUM_PHASES - 1;

  typedef enum logic {
    ROW_ITEM  = 1'b0,
    ROW_COUNT = 1'b1
  } row_kind_e;

  typedef enum int unsigned {
    FLOW_FREE,
    FLOW_SEND_IDLE,
    FLOW_RECV_STALL,
    FLOW_BOTH
  } flow_mode_e;

  typedef struct packed {
    func_e              func;
    logic [IDX_W-1:0]   entry_index;
    logic [COLOR_W-1:0] entry_color;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
  } palette_item_t;

  typedef struct packed {
    row_kind_e          kind;
    logic [CFG_W-1:0]   count;
    func_e              func;
    logic [IDX_W-1:0]   entry_index;
    logic [COLOR_W-1:0] entry_color;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               known;
    logic [IDX_W-1:0]   best;
  } directed_row_t;

  // directed stimulus: kind, count, func, index, color, red, green, blue, known, best
  directed_row_t directed_rows [NUM_ROWS] = '{
    // empty palette straight after reset, extremes of the query channels
    '{ROW_ITEM,  7'd0, FUNC_QUERY, 6'd0,  12'h000, 8'hFF, 8'hFF, 8'hFF, 1'b1, 6'd0},
    '{ROW_ITEM,  7'd0, FUNC_QUERY, 6'd63, 12'hFFF, 8'h00, 8'h00, 8'h00, 1'b1, 6'd0},
    // primary colors and the last store entry
    '{ROW_ITEM,  7'd0, FUNC_LOAD,  6'd0,  12'h000, 8'h00, 8'h00, 8'h00, 1'b0, 6'd0},
    '{ROW_ITEM,  7'd0, FUNC_LOAD,  6'd1,  12'hFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 6'd0},
    '{ROW_ITEM,  7'd0, FUNC_LOAD,  6'd2,  12'hF00, 8'h00, 8'h00, 8'h00, 1'b0, 6'd0},
    '{ROW_ITEM,  7'd0, FUNC_LOAD,  6'd3,  12'h0F0, 8'h00, 8'h00, 8'h00, 1'b0, 6'd0},
    '{ROW_ITEM,  7'd0, FUNC_LOAD,  6'd63, 12'h00F, 8'h00, 8'h00, 8'h00, 1'b0, 6'd0},
    '{ROW_COUNT, 7'd4, FUNC_LOAD,  6'd0,  12'h000, 8'h00, 8'h00, 8'h00, 1'b0, 6'd0},
    // exact matches of loaded entries
    '{ROW_ITEM,  7'd0, FUNC_QUERY, 6'd0,  12'h000, 8'h00, 8'h00, 8'h00, 1'b1, 6'd0},
    '{ROW_ITEM,  7'd0, FUNC_QUERY, 6'd0,  12'h000, 8'hFF, 8'hFF, 8'hFF, 1'b1, 6'd1},
    '{ROW_ITEM,  7'd0, FUNC_QUERY, 6'd0,  12'h000, 8'hF0, 8'h00, 8'h00, 1'b1, 6'd2},
    // low nibbles of the query are dropped
    '{ROW_ITEM,  7'd0, FUNC_QUERY, 6'd0,  12'h000, 8'h0F, 8'hFF, 8'h0F, 1'b0, 6'd0},
    // duplicate entry gives a tie, first one wins
    '{ROW_ITEM,  7'd0, FUNC_LOAD,  6'd2,  12'h000, 8'hFF, 8'hFF, 8'hFF, 1'b0, 6'd0},
    '{ROW_ITEM,  7'd0, FUNC_QUERY, 6'd0,  12'h000, 8'h10, 8'h10, 8'h10, 1'b0, 6'd0},
    // single entry palette
    '{ROW_COUNT, 7'd1, FUNC_LOAD,  6'd0,  12'h000, 8'h00, 8'h00, 8'h00, 1'b0, 6'd0},
    '{ROW_ITEM,  7'd0, FUNC_QUERY, 6'd0,  12'h000, 8'hFF, 8'hFF, 8'hFF, 1'b1, 6'd0},
    // back to an empty palette
    '{ROW_COUNT, 7'd0, FUNC_LOAD,  6'd0,  12'h000, 8'h00, 8'h00, 8'h00, 1'b0, 6'd0},
    '{ROW_ITEM,  7'd0, FUNC_QUERY, 6'd0,  12'h000, 8'h80, 8'h80, 8'h80, 1'b1, 6'd0}
  };

  logic [CFG_W-1:0] phase_counts [NUM_PHASES] = '{
    7'd64, 7'd127, 7'd1, 7'd0, 7'd65, 7'd32, 7'd2, 7'd100, 7'd63, 7'd16
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  npcs_cfg_if cfg_if ();
  npcs_in_if  item_if ();
  npcs_out_if result_if ();

  nearest_palette_color_search dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .item_i   (item_if),
    .result_o (result_if)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // shadow palette and color count
  logic [COLOR_W-1:0] palette_q [PALETTE_DEPTH];
  int unsigned        color_count_q;
  logic [IDX_W-1:0]   expected_best_q [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_req;
  int unsigned mismatches;
  int unsigned loads_sent;
  int unsigned queries_sent;
  int unsigned results_seen;
  int unsigned counts_written;

  function automatic int unsigned nib_sq(input logic [NIB_W-1:0] a, input logic [NIB_W-1:0] b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  // weighted rgb444 distance search over the searched part of the palette
  function automatic logic [IDX_W-1:0] nearest_entry(input logic [CHAN_W-1:0] red,
                                                     input logic [CHAN_W-1:0] green,
                                                     input logic [CHAN_W-1:0] blue);
    int unsigned span;
    int unsigned best;
    int unsigned best_dist;
    int unsigned entry_dist;
    int unsigned j;
    color_t      e;
    span      = (color_count_q > PALETTE_DEPTH) ? PALETTE_DEPTH : color_count_q;
    best      = 0;
    best_dist = 32'hFFFF_FFFF;
    for (j = 0; j < span; j++) begin
      e          = color_t'(palette_q[IDX_W'(j)]);
      entry_dist = W_RED   * nib_sq(red[CHAN_W-1 -: NIB_W], e.red)
                 + W_GREEN * nib_sq(green[CHAN_W-1 -: NIB_W], e.green)
                 + W_BLUE  * nib_sq(blue[CHAN_W-1 -: NIB_W], e.blue);
      if (entry_dist < best_dist) begin
        best_dist = entry_dist;
        best      = j;
      end
    end
    return IDX_W'(best);
  endfunction

  // random load or query, biased toward exact matches, ties and extremes
  function automatic palette_item_t random_item(input int unsigned query_pct);
    palette_item_t it;
    color_t        src;
    int unsigned   pick;
    it.func        = ($urandom_range(99) < query_pct) ? FUNC_QUERY : FUNC_LOAD;
    it.entry_index = IDX_W'($urandom_range(PALETTE_DEPTH - 1));
    it.entry_color = COLOR_W'($urandom_range(4095));
    it.red         = CHAN_W'($urandom_range(255));
    it.green       = CHAN_W'($urandom_range(255));
    it.blue        = CHAN_W'($urandom_range(255));
    pick           = $urandom_range(99);
    src            = color_t'(palette_q[IDX_W'($urandom_range(PALETTE_DEPTH - 1))]);
    if (it.func == FUNC_LOAD && pick < 10) begin
      it.entry_color = src;
    end else if (it.func == FUNC_QUERY && pick < 25) begin
      it.red   = {src.red,   it.red[NIB_W-1:0]};
      it.green = {src.green, it.green[NIB_W-1:0]};
      it.blue  = {src.blue,  it.blue[NIB_W-1:0]};
    end else if (it.func == FUNC_QUERY && pick < 30) begin
      it.red   = pick[0] ? 8'hFF : 8'h00;
      it.green = pick[0] ? 8'hFF : 8'h00;
      it.blue  = pick[0] ? 8'hFF : 8'h00;
    end
    return it;
  endfunction

  // offer one item after a random gap, update the shadow state on transfer
  task automatic send_item(input palette_item_t it, input logic known,
                           input logic [IDX_W-1:0] best);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.func        <= it.func;
    item_if.entry_index <= it.entry_index;
    item_if.entry_color <= it.entry_color;
    item_if.query_red   <= it.red;
    item_if.query_green <= it.green;
    item_if.query_blue  <= it.blue;
    do @(posedge clk_i); while (!item_if.ready);
    if (it.func == FUNC_LOAD) begin
      palette_q[it.entry_index] = it.entry_color;
      loads_sent++;
    end else begin
      expected_best_q.push_back(known ? best : nearest_entry(it.red, it.green, it.blue));
      queries_sent++;
    end
  endtask

  // wait for every pending result, then let a load finish
  task automatic settle();
    while (expected_best_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid  <= 1'b0;
    color_count_q = value;
    counts_written++;
  endtask

  // result sink: random stalls, long hold-off on request, in-order checking
  initial begin : result_sink
    int unsigned      hold_left;
    int unsigned      hold_seen;
    logic [IDX_W-1:0] want;
    hold_left       = 0;
    hold_seen       = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_if.valid && result_if.ready) begin
        results_seen++;
        if (expected_best_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected result: best_index %0d", result_if.best_index);
          mismatches++;
        end else begin
          want = expected_best_q.pop_front();
          if (result_if.best_index !== want) begin
            if (mismatches < MAX_REPORTS)
              $display("best_index mismatch: expected %0d, got %0d",
                       want, result_if.best_index);
            mismatches++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (cfg_if.valid && cfg_if.ready) || (item_if.valid && item_if.ready) ||
          (result_if.valid && result_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  // stimulus sequence
  initial begin : stimulus
    int unsigned   phase;
    int unsigned   k;
    int unsigned   query_pct;
    palette_item_t it;
    directed_row_t row;
    flow_mode_e    mode;
    logic [CFG_W-1:0] count;

    rst_ni              = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.data         = '0;
    item_if.valid       = 1'b0;
    item_if.func        = FUNC_LOAD;
    item_if.entry_index = '0;
    item_if.entry_color = '0;
    item_if.query_red   = '0;
    item_if.query_green = '0;
    item_if.query_blue  = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_req            = 0;
    mismatches          = 0;
    loads_sent          = 0;
    queries_sent        = 0;
    results_seen        = 0;
    counts_written      = 0;
    color_count_q       = 0;
    for (k = 0; k < PALETTE_DEPTH; k++) palette_q[IDX_W'(k)] = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (k = 0; k < NUM_ROWS; k++) begin
      row = directed_rows[k];
      if (row.kind == ROW_COUNT) begin
        item_if.valid <= 1'b0;
        settle();
        write_count(row.count);
      end else begin
        it.func        = row.func;
        it.entry_index = row.entry_index;
        it.entry_color = row.entry_color;
        it.red         = row.red;
        it.green       = row.green;
        it.blue        = row.blue;
        send_item(it, row.known, row.best);
      end
    end
    item_if.valid <= 1'b0;
    settle();

    // fill the whole store so any count searches written entries only
    for (k = 0; k < PALETTE_DEPTH; k++) begin
      it             = random_item(0);
      it.entry_index = IDX_W'(k);
      send_item(it, 1'b0, '0);
    end
    item_if.valid <= 1'b0;
    settle();

    // random phases over several counts and flow modes
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      count = (phase == RANDOM_PHASE) ? CFG_W'($urandom_range(127)) : phase_counts[phase];
      write_count(count);
      mode      = flow_mode_e'(phase % 4);
      query_pct = 50;
      if (phase == PRESSURE_PHASE) begin
        // output held off while queries keep coming, block backs up
        mode      = FLOW_FREE;
        query_pct = 90;
        hold_req++;
      end
      case (mode)
        FLOW_FREE: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        FLOW_SEND_IDLE: begin
          send_idle_pct  = 72;
          recv_stall_pct = 0;
        end
        FLOW_RECV_STALL: begin
          send_idle_pct  = 0;
          recv_stall_pct = 72;
        end
        default: begin
          send_idle_pct  = 28;
          recv_stall_pct = 28;
        end
      endcase
      for (k = 0; k < ITEMS_PER_PHASE; k++) send_item(random_item(query_pct), 1'b0, '0);
      item_if.valid <= 1'b0;
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_best_q.size() != 0) begin
      $display("%0d queries left without a result", expected_best_q.size());
      mismatches += expected_best_q.size();
    end
    $display("ran %0d palette loads and %0d queries across %0d color count writes",
             loads_sent, queries_sent, counts_written);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/npcs_pkg.sv
design/npcs_in_if.sv
design/npcs_out_if.sv
design/npcs_cfg_if.sv
design/npcs_ram.sv
design/npcs_dist.sv
design/npcs_seq.sv
design/nearest_palette_color_search.sv
design/npcs_checker.sv
test/tb_top.sv
